@@ rtl/cmare_pkg.sv @@
// ----------------------------------------------------------------------------
// cmare_pkg
// Shared types, widths and codes of the chord-modifier and axis-repeat engine.
// ----------------------------------------------------------------------------
package cmare_pkg;

	localparam int DEF_NUM_BUTTONS = 32;
	localparam int DEF_NUM_AXES    = 32;

	localparam int CH_W     = 5;
	localparam int DISP_W   = 16;
	localparam int MASK_W   = 32;
	localparam int SENS_W   = 16;
	localparam int MAG_W    = 15;
	localparam int PERIOD_W = 20;
	localparam int CFG_IDX_W = 2;

	localparam logic [CH_W-1:0] HAT_FIRST = 5'd16;
	localparam logic [CH_W-1:0] HAT_LAST  = 5'd23;
	localparam logic [MAG_W-1:0] FULL_SCALE = 15'h7FFF;
	localparam int Q12_SHIFT = 12;

	localparam logic [CFG_IDX_W-1:0] REG_TIMING_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_DIRECTION   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_SENSITIVITY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HAT_SENSITIVITY   = 2'd3;

	localparam logic [SENS_W-1:0] SENS_RESET = 16'd4096;

	typedef enum logic [1:0] {
		OP_BUTTON = 2'd0,
		OP_AXIS   = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		K_DOWN    = 3'd0,
		K_UP      = 3'd1,
		K_RELEASE = 3'd2,
		K_PREV    = 3'd3,
		K_CENTER  = 3'd4,
		K_NEXT    = 3'd5,
		K_PLAIN   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_WALK,
		ST_FLUSH
	} state_t;

endpackage

@@ rtl/cmare_divider.sv @@
// ----------------------------------------------------------------------------
// cmare_divider
// Restoring radix-2 divider, one quotient bit per cycle; result holds until
// the next start.
// ----------------------------------------------------------------------------
module cmare_divider
	import cmare_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PERIOD_W-1:0] dividend,
	input  logic [MAG_W-1:0]    divisor,
	output logic                busy,
	output logic [PERIOD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PERIOD_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] div_q;
	logic [PERIOD_W-1:0] quo_q;

	logic [MAG_W:0] shifted;
	logic [MAG_W:0] trial;
	logic           fits;

	assign shifted = {rem_q, quo_q[PERIOD_W-1]};
	assign trial   = shifted - {1'b0, div_q};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(PERIOD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
			quo_q <= {quo_q[PERIOD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/chord_modifier_axis_repeat_engine.sv @@
// Flow: a button or untimed axis request is executed in EXEC and its result
// loaded into the output register; a timed axis request with nonzero displacement
// first waits in DIV for the 20-step serial divider; a tick walks one axis a cycle
// in WALK unless a held output stalls it, and gives its last result, if any, from FLUSH.
// Requests are taken one at a time, only while the sequencer is idle.
// Reset clears the held and used button masks, repeat periods, countdowns and stored actions at once.
// ----------------------------------------------------------------------------
// chord_modifier_axis_repeat_engine
// Button chord tracking and axis repeat engine: sequencer, per-axis repeat
// state, shared period divider and output register.
// ----------------------------------------------------------------------------
module chord_modifier_axis_repeat_engine
	import cmare_pkg::*;
#(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
	parameter int NUM_AXES    = DEF_NUM_AXES
)(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [SENS_W-1:0]        cfg_data,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [DISP_W-1:0] displacement,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               kind,
	output logic [CH_W-1:0]          channel_out,
	output logic [MASK_W-1:0]        modifier_mask,
	output logic signed [DISP_W-1:0] amount,
	output logic                     has_amount,
	output logic                     last
);

	localparam int AXIS_IDX_W = $clog2(NUM_AXES);

	state_t state_q, state_d;

	logic              timing_q, split_q;
	logic [SENS_W-1:0] stick_sens_q, hat_sens_q;

	logic [1:0]               op_q;
	logic [CH_W-1:0]          ch_q;
	logic signed [DISP_W-1:0] disp_q;

	logic [MASK_W-1:0] held_q, held_d, used_q, used_d;

	logic [PERIOD_W-1:0] period_q [NUM_AXES];
	logic [PERIOD_W-1:0] cd_q     [NUM_AXES];
	kind_t               action_q [NUM_AXES];

	logic [AXIS_IDX_W-1:0] idx_q, idx_d;
	logic                  pend_valid_q, pend_valid_d;
	kind_t                 pend_kind_q, pend_kind_d;
	logic [CH_W-1:0]       pend_ch_q, pend_ch_d;

	logic                     out_valid_q;
	kind_t                    out_kind_q;
	logic [CH_W-1:0]          out_ch_q;
	logic [MASK_W-1:0]        out_mask_q;
	logic signed [DISP_W-1:0] out_amt_q;
	logic                     out_has_q;
	logic                     out_last_q;

	logic                     ld_out;
	kind_t                    ld_kind;
	logic [CH_W-1:0]          ld_ch;
	logic [MASK_W-1:0]        ld_mask;
	logic signed [DISP_W-1:0] ld_amt;
	logic                     ld_has;
	logic                     ld_last;
	logic                     out_free;

	logic                  wr_en;
	logic [AXIS_IDX_W-1:0] wr_addr;
	logic [PERIOD_W-1:0]   wr_period, wr_cd;
	kind_t                 wr_action;

	logic [AXIS_IDX_W-1:0] rd_addr;
	logic [PERIOD_W-1:0]   rd_period, rd_cd, cd_dec;
	kind_t                 rd_action;

	logic                btn_ok, axis_ok;
	logic [MASK_W-1:0]   btn_bit;
	logic                disp_neg, disp_zero;
	logic [DISP_W-1:0]   mag_full;
	logic [MAG_W-1:0]    mag;
	kind_t               axis_kind;
	logic                axis_has;
	logic signed [DISP_W-1:0] axis_amt;
	logic [SENS_W-1:0]   sens;
	logic [SENS_W+MAG_W-1:0] numer;

	logic                div_start, div_busy;
	logic [PERIOD_W-1:0] div_quot;

	cmare_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (PERIOD_W'(numer[SENS_W+MAG_W-1:Q12_SHIFT])),
		.divisor  (mag),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q     <= 1'b1;
			split_q      <= 1'b1;
			stick_sens_q <= SENS_RESET;
			hat_sens_q   <= SENS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIMING_MODE:       timing_q     <= cfg_data[0];
				REG_SPLIT_DIRECTION:   split_q      <= cfg_data[0];
				REG_STICK_SENSITIVITY: stick_sens_q <= cfg_data;
				REG_HAT_SENSITIVITY:   hat_sens_q   <= cfg_data;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= operation;
			ch_q   <= channel;
			disp_q <= displacement;
		end
	end

	assign btn_ok  = int'(ch_q) < NUM_BUTTONS;
	assign axis_ok = int'(ch_q) < NUM_AXES;
	assign btn_bit = MASK_W'(1) << ch_q;

	assign disp_neg  = disp_q[DISP_W-1];
	assign disp_zero = (disp_q == '0);
	assign mag_full  = disp_neg ? (~disp_q + DISP_W'(1)) : disp_q;
	assign mag       = mag_full[DISP_W-1] ? FULL_SCALE : mag_full[MAG_W-1:0];

	always_comb begin
		if (!split_q) begin
			axis_kind = K_PLAIN;
		end else if (disp_zero) begin
			axis_kind = K_CENTER;
		end else if (disp_neg) begin
			axis_kind = K_PREV;
		end else begin
			axis_kind = K_NEXT;
		end
	end

	assign axis_has = !(split_q && disp_zero);
	assign axis_amt = (split_q && disp_neg) ? signed'({1'b0, mag}) : disp_q;
	assign sens     = (ch_q >= HAT_FIRST && ch_q <= HAT_LAST) ? hat_sens_q : stick_sens_q;
	assign numer    = {sens, MAG_W'(0)} - (SENS_W+MAG_W)'(sens);

	assign rd_addr   = (state_q == ST_WALK) ? idx_q : ch_q[AXIS_IDX_W-1:0];
	assign rd_period = period_q[rd_addr];
	assign rd_cd     = cd_q[rd_addr];
	assign rd_action = action_q[rd_addr];
	assign cd_dec    = rd_cd - PERIOD_W'(1);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			held_q       <= '0;
			used_q       <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			held_q       <= held_d;
			used_q       <= used_d;
			idx_q        <= idx_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_kind_q <= pend_kind_d;
		pend_ch_q   <= pend_ch_d;
	end

	always_comb begin
		state_d      = state_q;
		held_d       = held_q;
		used_d       = used_q;
		idx_d        = idx_q;
		pend_valid_d = pend_valid_q;
		pend_kind_d  = pend_kind_q;
		pend_ch_d    = pend_ch_q;
		ld_out       = 1'b0;
		ld_kind      = axis_kind;
		ld_ch        = ch_q;
		ld_mask      = held_q;
		ld_amt       = '0;
		ld_has       = 1'b0;
		ld_last      = 1'b1;
		wr_en        = 1'b0;
		wr_addr      = ch_q[AXIS_IDX_W-1:0];
		wr_period    = '0;
		wr_cd        = '0;
		wr_action    = axis_kind;
		div_start    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (op_q)
					OP_BUTTON: begin
						if (!btn_ok) begin
							state_d = ST_IDLE;
						end else if (out_free) begin
							ld_out  = 1'b1;
							state_d = ST_IDLE;
							if (!disp_zero) begin
								ld_kind = K_DOWN;
								used_d  = used_q | held_q;
								held_d  = held_q | btn_bit;
							end else begin
								ld_kind = ((used_q & btn_bit) != '0) ? K_RELEASE : K_UP;
								used_d  = used_q & ~btn_bit;
								held_d  = held_q & ~btn_bit;
								ld_mask = held_q & ~btn_bit;
							end
						end
					end
					OP_AXIS: begin
						if (!axis_ok) begin
							state_d = ST_IDLE;
						end else if (timing_q && mag != '0) begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end else if (out_free) begin
							ld_out  = 1'b1;
							used_d  = used_q | held_q;
							state_d = ST_IDLE;
							if (timing_q) begin
								wr_en = 1'b1;
							end else begin
								ld_has = axis_has;
								ld_amt = axis_has ? axis_amt : '0;
							end
						end
					end
					OP_TICK: begin
						idx_d        = '0;
						pend_valid_d = 1'b0;
						state_d      = ST_WALK;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DIV: begin
				if (!div_busy && (rd_period != '0 || out_free)) begin
					ld_out    = (rd_period == '0);
					wr_en     = 1'b1;
					wr_period = div_quot;
					wr_cd     = div_quot;
					used_d    = used_q | held_q;
					state_d   = ST_IDLE;
				end
			end
			ST_WALK: begin
				wr_addr   = idx_q;
				wr_period = rd_period;
				wr_action = rd_action;
				if (!(rd_period != '0 && cd_dec == '0 && pend_valid_q && !out_free)) begin
					if (rd_period != '0) begin
						wr_en = 1'b1;
						if (cd_dec == '0) begin
							wr_cd        = rd_period;
							ld_out       = pend_valid_q;
							ld_kind      = pend_kind_q;
							ld_ch        = pend_ch_q;
							ld_last      = 1'b0;
							pend_valid_d = 1'b1;
							pend_kind_d  = rd_action;
							pend_ch_d    = CH_W'(idx_q);
							used_d       = used_q | held_q;
						end else begin
							wr_cd = cd_dec;
						end
					end
					if (idx_q == AXIS_IDX_W'(NUM_AXES - 1)) begin
						state_d = ST_FLUSH;
					end else begin
						idx_d = idx_q + AXIS_IDX_W'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					ld_out       = 1'b1;
					ld_kind      = pend_kind_q;
					ld_ch        = pend_ch_q;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				period_q[i] <= '0;
				cd_q[i]     <= '0;
				action_q[i] <= K_PLAIN;
			end
		end else if (wr_en) begin
			period_q[wr_addr] <= wr_period;
			cd_q[wr_addr]     <= wr_cd;
			action_q[wr_addr] <= wr_action;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_kind_q <= ld_kind;
			out_ch_q   <= ld_ch;
			out_mask_q <= ld_mask;
			out_amt_q  <= ld_amt;
			out_has_q  <= ld_has;
			out_last_q <= ld_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign channel_out   = out_ch_q;
	assign modifier_mask = out_mask_q;
	assign amount        = out_amt_q;
	assign has_amount    = out_has_q;
	assign last          = out_last_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the chord-modifier and axis-repeat engine. A directed script
// covers the button, axis, tick and unused requests and the field extremes.
// Random phases follow, each with its own register settings. Every result is
// checked field by field against a scripted value or a joystick state predictor.
// ----------------------------------------------------------------------------
module testbench;
	import cmare_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 8;
	localparam int PHASE_REQUESTS = 54;

	typedef struct packed {
		logic [2:0]        kind;
		logic [CH_W-1:0]   ch;
		logic [MASK_W-1:0] mask;
		logic [DISP_W-1:0] amount;
		logic              has;
		logic              last;
	} joy_event_t;

	typedef struct {
		bit                       is_reg;
		logic [CFG_IDX_W-1:0]     idx;
		logic [SENS_W-1:0]        data;
		logic [1:0]               op;
		logic [CH_W-1:0]          ch;
		logic signed [DISP_W-1:0] disp;
		bit                       typed;
		joy_event_t               want;
	} script_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [SENS_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               operation;
	logic [CH_W-1:0]          channel;
	logic signed [DISP_W-1:0] displacement;
	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               kind;
	logic [CH_W-1:0]          channel_out;
	logic [MASK_W-1:0]        modifier_mask;
	logic signed [DISP_W-1:0] amount;
	logic                     has_amount;
	logic                     last;

	// predictor state
	logic              timing_on = 1'b1;
	logic              split_on = 1'b1;
	logic [SENS_W-1:0] stick_sens = SENS_RESET;
	logic [SENS_W-1:0] hat_sens = SENS_RESET;
	logic [MASK_W-1:0] held_buttons = '0;
	logic [MASK_W-1:0] chord_buttons = '0;
	logic [PERIOD_W-1:0] repeat_len [DEF_NUM_AXES] = '{default: '0};
	logic [PERIOD_W-1:0] repeat_left [DEF_NUM_AXES] = '{default: '0};
	kind_t               repeat_kind [DEF_NUM_AXES] = '{default: K_PLAIN};

	joy_event_t  step_events[$];
	joy_event_t  due_events[$];
	script_row_t script[$];
	joy_event_t  oldest;

	bit failed = 1'b0;
	bit feed_calm = 1'b0;
	bit sink_calm = 1'b0;
	int stall_left = 0;
	int sink_cycles = 0;
	int idle_cycles = 0;

	chord_modifier_axis_repeat_engine dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic joy_event_t make_event(kind_t k, logic [CH_W-1:0] c,
			logic [MASK_W-1:0] m, logic signed [DISP_W-1:0] a, logic h, logic l);
		joy_event_t e;
		e.kind = k;
		e.ch = c;
		e.mask = m;
		e.amount = a;
		e.has = h;
		e.last = l;
		return e;
	endfunction

	function automatic void emit(kind_t k, logic [CH_W-1:0] c, logic [MASK_W-1:0] m,
			logic signed [DISP_W-1:0] a, logic h);
		step_events.push_back(make_event(k, c, m, a, h, 1'b0));
	endfunction

	function automatic void joy_step(logic [1:0] op, logic [CH_W-1:0] ch,
			logic signed [DISP_W-1:0] disp);
		int                       v;
		int                       mag;
		longint                   q;
		logic [MASK_W-1:0]        bitm;
		kind_t                    k;
		logic signed [DISP_W-1:0] amt;
		logic                     has;
		logic [SENS_W-1:0]        sens;
		step_events.delete();
		v = disp;
		mag = (v < 0) ? -v : v;
		if (mag > FULL_SCALE) mag = FULL_SCALE;
		bitm = MASK_W'(1) << ch;
		case (op)
		OP_BUTTON: begin
			if (v != 0) begin
				emit(K_DOWN, ch, held_buttons, '0, 1'b0);
				chord_buttons |= held_buttons;
				held_buttons |= bitm;
			end else begin
				k = ((chord_buttons & bitm) != 0) ? K_RELEASE : K_UP;
				chord_buttons &= ~bitm;
				held_buttons &= ~bitm;
				emit(k, ch, held_buttons, '0, 1'b0);
			end
		end
		OP_AXIS: begin
			has = 1'b1;
			if (!split_on) begin
				k = K_PLAIN;
				amt = disp;
			end else if (v == 0) begin
				k = K_CENTER;
				amt = '0;
				has = 1'b0;
			end else if (v < 0) begin
				k = K_PREV;
				amt = DISP_W'(mag);
			end else begin
				k = K_NEXT;
				amt = disp;
			end
			if (timing_on) begin
				sens = (ch >= HAT_FIRST && ch <= HAT_LAST) ? hat_sens : stick_sens;
				if (mag == 0 || repeat_len[ch] == 0) emit(k, ch, held_buttons, '0, 1'b0);
				q = (mag == 0) ? 0 :
					(longint'(sens) * FULL_SCALE) / (longint'(mag) << Q12_SHIFT);
				repeat_len[ch] = PERIOD_W'(q);
				repeat_left[ch] = PERIOD_W'(q);
				repeat_kind[ch] = k;
			end else begin
				emit(k, ch, held_buttons, amt, has);
			end
			chord_buttons |= held_buttons;
		end
		OP_TICK: begin
			for (int i = 0; i < DEF_NUM_AXES; i++) begin
				if (repeat_len[i] != 0) begin
					repeat_left[i] = repeat_left[i] - 1'b1;
					if (repeat_left[i] == 0) begin
						repeat_left[i] = repeat_len[i];
						emit(repeat_kind[i], CH_W'(i), held_buttons, '0, 1'b0);
						chord_buttons |= held_buttons;
					end
				end
			end
		end
		default: ;
		endcase
		if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [SENS_W-1:0] data);
		script_row_t r;
		r = '{default: '0};
		r.is_reg = 1'b1;
		r.idx = idx;
		r.data = data;
		script.push_back(r);
	endfunction

	function automatic void add_item(logic [1:0] op, logic [CH_W-1:0] ch,
			logic signed [DISP_W-1:0] disp);
		script_row_t r;
		r = '{default: '0};
		r.op = op;
		r.ch = ch;
		r.disp = disp;
		script.push_back(r);
	endfunction

	function automatic void add_checked(logic [1:0] op, logic [CH_W-1:0] ch,
			logic signed [DISP_W-1:0] disp, kind_t k, logic [MASK_W-1:0] m,
			logic signed [DISP_W-1:0] a, logic h);
		script_row_t r;
		r = '{default: '0};
		r.op = op;
		r.ch = ch;
		r.disp = disp;
		r.typed = 1'b1;
		r.want = make_event(k, ch, m, a, h, 1'b1);
		script.push_back(r);
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(1, 3);
		if (r < 92) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SENS_W-1:0] pick_sens();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return SENS_RESET;
		default: return SENS_W'($urandom_range(512, 16384));
		endcase
	endfunction

	function automatic void check_field(string name, longint want_v, longint got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			failed = 1'b1;
		end
	endfunction

	task automatic send_event(logic [1:0] op, logic [CH_W-1:0] ch,
			logic signed [DISP_W-1:0] disp, bit typed, joy_event_t want);
		int gap;
		gap = (feed_calm || $urandom_range(0, 9) < 4) ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		channel = ch;
		displacement = disp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		joy_step(op, ch, disp);
		if (typed) due_events.push_back(want);
		else foreach (step_events[i]) due_events.push_back(step_events[i]);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SENS_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
		REG_TIMING_MODE:       timing_on = data[0];
		REG_SPLIT_DIRECTION:   split_on = data[0];
		REG_STICK_SENSITIVITY: stick_sens = data;
		REG_HAT_SENSITIVITY:   hat_sens = data;
		default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drain all results, then let a silent divide or tick walk finish
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (due_events.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			sink_cycles++;
			if (sink_cycles % 256 == 0) sink_calm = ($urandom_range(0, 3) == 0);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_events.size() == 0) begin
				$error("result with nothing pending: kind %0d channel %0d", kind, channel_out);
				failed = 1'b1;
			end else begin
				oldest = due_events.pop_front();
				check_field("kind", oldest.kind, kind);
				check_field("channel_out", oldest.ch, channel_out);
				check_field("modifier_mask", oldest.mask, modifier_mask);
				check_field("amount", $signed(oldest.amount), amount);
				check_field("has_amount", oldest.has, has_amount);
				check_field("last", oldest.last, last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("chord_modifier_axis_repeat_engine regression: fail");
			$finish;
		end
	end

	initial begin
		int                       count;
		int                       pick;
		logic [1:0]               op;
		logic [CH_W-1:0]          ch;
		logic signed [DISP_W-1:0] disp;
		logic                     t_mode;
		logic                     s_mode;
		logic [SENS_W-1:0]        st;
		logic [SENS_W-1:0]        ht;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = '0;
		channel = '0;
		displacement = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_checked(OP_BUTTON, 5'd0, 16'sd1, K_DOWN, 32'h0, '0, 1'b0);
		add_checked(OP_BUTTON, 5'd31, 16'sh8000, K_DOWN, 32'h1, '0, 1'b0);
		add_checked(OP_BUTTON, 5'd31, 16'sd0, K_UP, 32'h1, '0, 1'b0);
		add_checked(OP_BUTTON, 5'd0, 16'sd0, K_RELEASE, 32'h0, '0, 1'b0);
		add_checked(OP_AXIS, 5'd0, 16'sd0, K_CENTER, 32'h0, '0, 1'b0);
		add_checked(OP_AXIS, 5'd5, 16'sh7FFF, K_NEXT, 32'h0, '0, 1'b0);
		add_checked(OP_AXIS, 5'd20, 16'sh8000, K_PREV, 32'h0, '0, 1'b0);
		add_item(OP_AXIS, 5'd5, 16'sd16384);
		add_item(OP_TICK, 5'd0, 16'sd0);
		add_item(OP_UNUSED, 5'd31, -16'sd1);
		add_item(OP_BUTTON, 5'd12, 16'sd5);
		add_item(OP_AXIS, 5'd31, -16'sd1);
		add_item(OP_BUTTON, 5'd12, 16'sd0);
		add_item(OP_TICK, 5'd31, 16'sh7FFF);
		add_reg(REG_TIMING_MODE, 16'd0);
		add_reg(REG_SPLIT_DIRECTION, 16'd0);
		add_checked(OP_AXIS, 5'd3, 16'sh8000, K_PLAIN, 32'h0, 16'sh8000, 1'b1);
		add_checked(OP_AXIS, 5'd3, 16'sh7FFF, K_PLAIN, 32'h0, 16'sh7FFF, 1'b1);
		add_item(OP_TICK, 5'd0, 16'sd0);
		add_reg(REG_SPLIT_DIRECTION, 16'd1);
		add_checked(OP_AXIS, 5'd7, 16'sh8000, K_PREV, 32'h0, 16'sh7FFF, 1'b1);
		add_checked(OP_AXIS, 5'd7, 16'sd0, K_CENTER, 32'h0, '0, 1'b0);
		add_item(OP_AXIS, 5'd7, 16'sd100);
		add_reg(REG_TIMING_MODE, 16'd1);
		add_reg(REG_STICK_SENSITIVITY, 16'hFFFF);
		add_reg(REG_HAT_SENSITIVITY, 16'h0000);
		add_item(OP_AXIS, 5'd16, 16'sd1);
		add_item(OP_AXIS, 5'd9, 16'sd1);
		add_item(OP_AXIS, 5'd5, 16'sd0);
		add_item(OP_TICK, 5'd0, 16'sd0);
		add_reg(REG_STICK_SENSITIVITY, 16'h0000);
		add_item(OP_AXIS, 5'd1, 16'sh7FFF);

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				settle();
				write_reg(script[i].idx, script[i].data);
			end else begin
				send_event(script[i].op, script[i].ch, script[i].disp, script[i].typed,
					script[i].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: begin
				t_mode = 1'b1;
				s_mode = 1'b1;
				st = '1;
				ht = '0;
			end
			1: begin
				t_mode = 1'b0;
				s_mode = 1'b0;
				st = '0;
				ht = '1;
			end
			default: begin
				t_mode = ($urandom_range(0, 3) != 0);
				s_mode = $urandom_range(0, 1);
				st = pick_sens();
				ht = pick_sens();
			end
			endcase
			settle();
			write_reg(REG_TIMING_MODE, SENS_W'(t_mode));
			write_reg(REG_SPLIT_DIRECTION, SENS_W'(s_mode));
			write_reg(REG_STICK_SENSITIVITY, st);
			write_reg(REG_HAT_SENSITIVITY, ht);
			feed_calm = ($urandom_range(0, 3) == 0);
			count = 0;
			while (count < PHASE_REQUESTS) begin
				pick = $urandom_range(0, 99);
				ch = CH_W'($urandom_range(0, 31));
				disp = DISP_W'($urandom);
				if (pick < 30) begin
					op = OP_BUTTON;
					// favor a few buttons so chords build up and break
					if ($urandom_range(0, 1)) ch = CH_W'($urandom_range(0, 3));
					disp = $urandom_range(0, 1) ? '0 : DISP_W'($urandom_range(1, 65535));
				end else if (pick < 65) begin
					op = OP_AXIS;
					case ($urandom_range(0, 3))
					0: ch = CH_W'($urandom_range(14, 25));
					1: ch = CH_W'($urandom_range(0, 3));
					default: ;
					endcase
					case ($urandom_range(0, 7))
					0: disp = '0;
					1: disp = 16'sh8000;
					2: disp = 16'sh7FFF;
					3, 4, 5: begin
						disp = DISP_W'($urandom_range(8192, 32767));
						if ($urandom_range(0, 1)) disp = -disp;
					end
					default: ;
					endcase
				end else if (pick < 95) begin
					op = OP_TICK;
				end else begin
					op = OP_UNUSED;
				end
				send_event(op, ch, disp, 1'b0, '0);
				if (op != OP_UNUSED) count++;
			end
		end

		settle();
		if (!failed)
			$display("chord_modifier_axis_repeat_engine regression: pass");
		else
			$display("chord_modifier_axis_repeat_engine regression: fail");
		$finish;
	end

endmodule

@@ chord_modifier_axis_repeat_engine.f @@
rtl/cmare_pkg.sv
rtl/cmare_divider.sv
rtl/chord_modifier_axis_repeat_engine.sv
tb/sv/testbench.sv
